### design/rpt_pkg.sv
// Shared types, constants and control structures of the ranging peer table.
package rpt_pkg;

	localparam int SLOTS = 8;
	localparam int ROUNDS = 8;
	localparam int BURST_WAIT_MS = 500;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int CNT_W = $clog2(ROUNDS + 1);
	localparam int ACT_W = $clog2(SLOTS + 1);
	localparam int RING_DEPTH = SLOTS * ROUNDS;
	localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int TREE_LV = (SLOTS > 1) ? $clog2(SLOTS) : 0;
	localparam int TREE_N = 1 << TREE_LV;

	localparam int OP_W = 2;
	localparam int ADDR_W = 16;
	localparam int DIST_W = 21;
	localparam int TIME_W = 32;
	localparam int RANGE_W = 20;
	localparam int SLOT_W = 3;
	localparam int STATUS_W = 3;
	localparam int SCNT_W = 4;
	localparam int ACNT_W = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 8'd1;

	localparam logic [TIME_W-1:0] STALE_TIMEOUT_RESET = 32'd5000;
	localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 20'd100000;

	typedef enum logic [OP_W-1:0] {
		OP_RANGE    = 2'd0,
		OP_TOUCH    = 2'd1,
		OP_INACTIVE = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT    = 3'd0,
		ST_NEW    = 3'd1,
		ST_EVICT  = 3'd2,
		ST_MISS   = 3'd3,
		ST_REJECT = 3'd4,
		ST_TICK   = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_COMMIT = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} rpt_cmd_t;

endpackage

### design/rpt_ctrl.sv
// Controller of the ranging peer table: sequences capture and commit of each item.
module rpt_ctrl import rpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rpt_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				// The result register must be free or draining before the commit.
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_COMMIT: begin
				cmd.commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/rpt_datapath.sv
// Datapath of the ranging peer table: slot store, lookup stage, update logic and result register.
module rpt_datapath import rpt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rpt_cmd_t              cmd,
	input  logic [OP_W-1:0]       operation,
	input  logic [ADDR_W-1:0]     peer_address,
	input  logic signed [DIST_W-1:0] distance_mm,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [SLOT_W-1:0]     slot_index,
	output logic [STATUS_W-1:0]   status,
	output logic [SCNT_W-1:0]     sample_count,
	output logic [ACNT_W-1:0]     active_count,
	output logic                  burst_done
);

	// Configuration registers.
	logic [TIME_W-1:0]  stale_to_q;
	logic [RANGE_W-1:0] max_range_q;

	// Slot store.
	logic [SLOTS-1:0]   valid_q;
	logic [ADDR_W-1:0]  addr_q [SLOTS];
	logic [RANGE_W-1:0] last_q [SLOTS];
	logic [TIME_W-1:0]  ts_q   [SLOTS];
	logic [CNT_W-1:0]   rc_q   [SLOTS];
	logic [POS_W-1:0]   wp_q   [SLOTS];
	logic               dirty_q;
	logic [RANGE_W-1:0] ring_mem [RING_DEPTH];

	// Next slot state.
	logic [SLOTS-1:0]   valid_d;
	logic [ADDR_W-1:0]  addr_d [SLOTS];
	logic [RANGE_W-1:0] last_d [SLOTS];
	logic [TIME_W-1:0]  ts_d   [SLOTS];
	logic [CNT_W-1:0]   rc_d   [SLOTS];
	logic [POS_W-1:0]   wp_d   [SLOTS];
	logic               dirty_d;

	// Lookup, computed from the input item and the current store.
	logic               hit_c;
	logic [IDX_W-1:0]   hit_idx_c;
	logic               free_c;
	logic [IDX_W-1:0]   free_idx_c;
	logic [TIME_W-1:0]  age_c [SLOTS];
	logic [SLOTS-1:0]   stale_c;
	logic [SLOTS-1:0]   near_c;
	logic               reject_c;
	logic [TIME_W-1:0]  tree_ts  [TREE_LV+1][TREE_N];
	logic [IDX_W-1:0]   tree_idx [TREE_LV+1][TREE_N];

	// Lookup stage registers.
	op_t                op_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [RANGE_W-1:0] dist_s1;
	logic [TIME_W-1:0]  now_s1;
	logic               hit_s1;
	logic [IDX_W-1:0]   hit_idx_s1;
	logic               free_s1;
	logic [IDX_W-1:0]   free_idx_s1;
	logic [IDX_W-1:0]   min_idx_s1;
	logic [SLOTS-1:0]   stale_s1;
	logic [SLOTS-1:0]   near_s1;
	logic               reject_s1;

	// Commit logic.
	logic [IDX_W-1:0]   sel;
	status_t            sel_st;
	logic [CNT_W-1:0]   rc_base;
	logic [POS_W-1:0]   wp_base;
	logic               ring_we;
	logic [RING_AW-1:0] ring_addr;
	logic               any_active;
	logic               all_done;
	logic [ACT_W-1:0]   act_cnt;
	logic [SLOT_W-1:0]  slot_d;
	status_t            status_d;
	logic [SCNT_W-1:0]  samp_d;
	logic               done_d;

	logic [SLOT_W-1:0]   slot_q;
	status_t             status_q;
	logic [SCNT_W-1:0]   samp_q;
	logic [ACNT_W-1:0]   act_q;
	logic                done_q;

	// Address match and first free slot; scanning downward leaves the lowest index.
	always_comb begin
		hit_c      = 1'b0;
		hit_idx_c  = '0;
		free_c     = 1'b0;
		free_idx_c = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && (addr_q[i] == peer_address)) begin
				hit_c     = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_c     = 1'b1;
				free_idx_c = IDX_W'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			age_c[i]   = now_ms - ts_q[i];
			stale_c[i] = valid_q[i] && (age_c[i] > stale_to_q);
			near_c[i]  = age_c[i] <= TIME_W'(BURST_WAIT_MS);
		end
		reject_c = distance_mm[DIST_W-1] || (distance_mm[RANGE_W-1:0] > max_range_q);
	end

	// Oldest timestamp by a compare tree; the left side wins a tie so the lowest
	// index is kept. Padding leaves carry the largest time and never win.
	always_comb begin
		for (int j = 0; j < TREE_N; j++) begin
			if (j < SLOTS) begin
				tree_ts[0][j]  = ts_q[j];
				tree_idx[0][j] = IDX_W'(j);
			end else begin
				tree_ts[0][j]  = '1;
				tree_idx[0][j] = '0;
			end
		end
		for (int l = 1; l <= TREE_LV; l++) begin
			for (int j = 0; j < TREE_N; j++) begin
				if (j < (TREE_N >> l)) begin
					if (tree_ts[l-1][2*j] <= tree_ts[l-1][2*j+1]) begin
						tree_ts[l][j]  = tree_ts[l-1][2*j];
						tree_idx[l][j] = tree_idx[l-1][2*j];
					end else begin
						tree_ts[l][j]  = tree_ts[l-1][2*j+1];
						tree_idx[l][j] = tree_idx[l-1][2*j+1];
					end
				end else begin
					tree_ts[l][j]  = '1;
					tree_idx[l][j] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1       <= op_t'(operation);
			addr_s1     <= peer_address;
			dist_s1     <= distance_mm[RANGE_W-1:0];
			now_s1      <= now_ms;
			hit_s1      <= hit_c;
			hit_idx_s1  <= hit_idx_c;
			free_s1     <= free_c;
			free_idx_s1 <= free_idx_c;
			min_idx_s1  <= tree_idx[TREE_LV][0];
			stale_s1    <= stale_c;
			near_s1     <= near_c;
			reject_s1   <= reject_c;
		end
	end

	always_comb begin
		sel     = hit_s1 ? hit_idx_s1 : (free_s1 ? free_idx_s1 : min_idx_s1);
		sel_st  = hit_s1 ? ST_HIT : (free_s1 ? ST_NEW : ST_EVICT);
		// A claimed slot that was not a hit starts from an empty ring.
		rc_base = (sel_st == ST_HIT) ? rc_q[sel] : '0;
		wp_base = (sel_st == ST_HIT) ? wp_q[sel] : '0;
		ring_addr = RING_AW'(sel) * RING_AW'(ROUNDS) + RING_AW'(wp_base);
	end

	always_comb begin
		valid_d = valid_q;
		addr_d  = addr_q;
		last_d  = last_q;
		ts_d    = ts_q;
		rc_d    = rc_q;
		wp_d    = wp_q;
		dirty_d = dirty_q;
		ring_we = 1'b0;
		any_active = 1'b0;
		all_done   = 1'b1;
		slot_d   = '0;
		status_d = ST_TICK;
		samp_d   = '0;
		done_d   = 1'b0;
		unique case (op_s1)
			OP_RANGE: begin
				if (reject_s1) begin
					status_d = ST_REJECT;
				end else begin
					valid_d[sel] = 1'b1;
					ts_d[sel]    = now_s1;
					dirty_d      = 1'b1;
					if (sel_st != ST_HIT) begin
						addr_d[sel] = addr_s1;
					end
					last_d[sel] = dist_s1;
					ring_we     = 1'b1;
					wp_d[sel]   = (wp_base == POS_W'(ROUNDS - 1)) ? '0 : wp_base + 1'b1;
					rc_d[sel]   = (rc_base < CNT_W'(ROUNDS)) ? rc_base + 1'b1 : rc_base;
					slot_d      = SLOT_W'(sel);
					status_d    = sel_st;
					samp_d      = SCNT_W'(rc_d[sel]);
				end
			end
			OP_TOUCH: begin
				valid_d[sel] = 1'b1;
				ts_d[sel]    = now_s1;
				dirty_d      = 1'b1;
				if (sel_st != ST_HIT) begin
					addr_d[sel] = addr_s1;
					last_d[sel] = '0;
				end
				rc_d[sel] = rc_base;
				wp_d[sel] = wp_base;
				slot_d    = SLOT_W'(sel);
				status_d  = sel_st;
				samp_d    = SCNT_W'(rc_base);
			end
			OP_INACTIVE: begin
				if (hit_s1) begin
					valid_d[hit_idx_s1] = 1'b0;
					last_d[hit_idx_s1]  = '0;
					rc_d[hit_idx_s1]    = '0;
					wp_d[hit_idx_s1]    = '0;
					dirty_d  = 1'b1;
					slot_d   = SLOT_W'(hit_idx_s1);
					status_d = ST_HIT;
				end else begin
					status_d = ST_MISS;
				end
			end
			OP_TICK: begin
				valid_d = valid_q & ~stale_s1;
				dirty_d = dirty_q || (|stale_s1);
				if (dirty_d) begin
					any_active = |valid_d;
					for (int i = 0; i < SLOTS; i++) begin
						if (valid_d[i] && (rc_q[i] < CNT_W'(ROUNDS)) && near_s1[i]) begin
							all_done = 1'b0;
						end
					end
					if (any_active && all_done) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (valid_d[i]) begin
								rc_d[i] = '0;
								wp_d[i] = '0;
							end
						end
						done_d = 1'b1;
					end
				end
				status_d = ST_TICK;
			end
			default: status_d = ST_TICK;
		endcase
	end

	always_comb begin
		act_cnt = '0;
		for (int i = 0; i < SLOTS; i++) begin
			act_cnt = act_cnt + ACT_W'(valid_d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				addr_q[i] <= '0;
				last_q[i] <= '0;
				ts_q[i]   <= '0;
				rc_q[i]   <= '0;
				wp_q[i]   <= '0;
			end
		end else if (cmd.commit) begin
			valid_q <= valid_d;
			dirty_q <= dirty_d;
			addr_q  <= addr_d;
			last_q  <= last_d;
			ts_q    <= ts_d;
			rc_q    <= rc_d;
			wp_q    <= wp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && ring_we) begin
			ring_mem[ring_addr] <= dist_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_to_q  <= STALE_TIMEOUT_RESET;
			max_range_q <= MAX_RANGE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_STALE_TIMEOUT) begin
				stale_to_q <= cfg_data;
			end else if (cfg_index == CFG_MAX_RANGE) begin
				max_range_q <= cfg_data[RANGE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_q   <= slot_d;
			status_q <= status_d;
			samp_q   <= samp_d;
			act_q    <= ACNT_W'(act_cnt);
			done_q   <= done_d;
		end
	end

	assign slot_index   = slot_q;
	assign status       = status_q;
	assign sample_count = samp_q;
	assign active_count = act_q;
	assign burst_done   = done_q;

endmodule

### design/ranging_peer_table.sv
// Top level of the ranging peer table: controller, datapath and configuration port.
//
// An item (operation, peer_address, distance_mm, now_ms) is taken as a transaction
// on in_valid/in_ready. Range, touch, inactive and tick items each give exactly one
// result on out_valid/out_ready: slot_index, status, sample_count, active_count and
// burst_done.
// In the accept cycle the address match, the free slot search, the oldest timestamp
// tree and the age compares run over all slots and are registered in the lookup
// stage; the commit state then writes the slot store back and loads the result
// register, waiting while an earlier result is still held. A new item is taken only
// after the previous one has committed.
// The result register separates the two sides: a new item is accepted while a
// result still waits, and its commit waits for the result register to drain if
// the receiver stalls.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and cfg_data
// and are taken in any cycle; index 0 is the stale timeout, index 1 the maximum
// range. They are meant to be issued only while the table is idle.
// Reset empties the table, clears the dirty flag and restores the register defaults.
module ranging_peer_table import rpt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic [ADDR_W-1:0]        peer_address,
	input  logic signed [DIST_W-1:0] distance_mm,
	input  logic [TIME_W-1:0]        now_ms,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SLOT_W-1:0]        slot_index,
	output logic [STATUS_W-1:0]      status,
	output logic [SCNT_W-1:0]        sample_count,
	output logic [ACNT_W-1:0]        active_count,
	output logic                     burst_done,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	rpt_cmd_t cmd;

	assign cfg_ready = 1'b1;

	rpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	rpt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.peer_address (peer_address),
		.distance_mm  (distance_mm),
		.now_ms       (now_ms),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.slot_index   (slot_index),
		.status       (status),
		.sample_count (sample_count),
		.active_count (active_count),
		.burst_done   (burst_done)
	);

endmodule

### sim/rpt_checker.sv
// Checker of the ranging peer table: predicts each result from the input stream and compares it.
`timescale 1ns / 1ps
module rpt_checker import rpt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic [ADDR_W-1:0]        peer_address,
	input  logic signed [DIST_W-1:0] distance_mm,
	input  logic [TIME_W-1:0]        now_ms,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [SLOT_W-1:0]        slot_index,
	input  logic [STATUS_W-1:0]      status,
	input  logic [SCNT_W-1:0]        sample_count,
	input  logic [ACNT_W-1:0]        active_count,
	input  logic                     burst_done,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output int                       mismatches,
	output int                       outstanding
);

	typedef struct {
		logic [SLOT_W-1:0] slot;
		status_t           st;
		logic [SCNT_W-1:0] samples;
		logic [ACNT_W-1:0] active;
		logic              done;
	} peer_result_t;

	logic              peer_valid  [SLOTS];
	logic [ADDR_W-1:0] peer_addr   [SLOTS];
	logic [TIME_W-1:0] peer_stamp  [SLOTS];
	logic [CNT_W-1:0]  burst_count [SLOTS];
	logic              table_touched;
	logic [TIME_W-1:0] stale_limit;
	logic [RANGE_W-1:0] range_limit;

	peer_result_t expected_results[$];
	peer_result_t want;

	function automatic int find_peer(logic [ADDR_W-1:0] a);
		for (int i = 0; i < SLOTS; i++)
			if (peer_valid[i] && peer_addr[i] == a)
				return i;
		return -1;
	endfunction

	// Hit first, then the lowest free slot, then the oldest stamp with the lowest index.
	function automatic int choose_slot(logic [ADDR_W-1:0] a, output status_t st);
		int s;
		logic [TIME_W-1:0] oldest;
		s = find_peer(a);
		st = ST_HIT;
		if (s >= 0)
			return s;
		st = ST_NEW;
		for (int i = 0; i < SLOTS; i++)
			if (!peer_valid[i])
				return i;
		st = ST_EVICT;
		s = 0;
		oldest = '1;
		for (int i = 0; i < SLOTS; i++) begin
			if (peer_stamp[i] < oldest) begin
				oldest = peer_stamp[i];
				s = i;
			end
		end
		return s;
	endfunction

	function automatic void claim_slot(int s, logic [ADDR_W-1:0] a, status_t st,
			logic [TIME_W-1:0] t);
		if (st != ST_HIT) begin
			peer_addr[s] = a;
			burst_count[s] = '0;
		end
		peer_valid[s] = 1'b1;
		peer_stamp[s] = t;
		table_touched = 1'b1;
	endfunction

	function automatic peer_result_t predict_result(op_t op, logic [ADDR_W-1:0] a,
			logic [DIST_W-1:0] d, logic [TIME_W-1:0] t);
		peer_result_t r;
		int s;
		status_t st;
		logic any_active;
		logic all_done;
		logic [TIME_W-1:0] age;
		logic [ACNT_W-1:0] n;
		r.slot = '0;
		r.st = ST_TICK;
		r.samples = '0;
		r.done = 1'b0;
		case (op)
			OP_RANGE: begin
				if (d[DIST_W-1] || d[RANGE_W-1:0] > range_limit) begin
					r.st = ST_REJECT;
				end else begin
					s = choose_slot(a, st);
					claim_slot(s, a, st, t);
					if (burst_count[s] < ROUNDS)
						burst_count[s]++;
					r.slot = s[SLOT_W-1:0];
					r.st = st;
					r.samples = burst_count[s];
				end
			end
			OP_TOUCH: begin
				s = choose_slot(a, st);
				claim_slot(s, a, st, t);
				r.slot = s[SLOT_W-1:0];
				r.st = st;
				r.samples = burst_count[s];
			end
			OP_INACTIVE: begin
				s = find_peer(a);
				if (s >= 0) begin
					peer_valid[s] = 1'b0;
					burst_count[s] = '0;
					table_touched = 1'b1;
					r.slot = s[SLOT_W-1:0];
					r.st = ST_HIT;
				end else begin
					r.st = ST_MISS;
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++) begin
					age = t - peer_stamp[i];
					if (peer_valid[i] && age > stale_limit) begin
						peer_valid[i] = 1'b0;
						table_touched = 1'b1;
					end
				end
				if (table_touched) begin
					any_active = 1'b0;
					all_done = 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						age = t - peer_stamp[i];
						if (peer_valid[i]) begin
							any_active = 1'b1;
							if (burst_count[i] < ROUNDS && age <= BURST_WAIT_MS)
								all_done = 1'b0;
						end
					end
					if (any_active && all_done) begin
						for (int i = 0; i < SLOTS; i++)
							if (peer_valid[i])
								burst_count[i] = '0;
						r.done = 1'b1;
					end
				end
			end
		endcase
		n = '0;
		for (int i = 0; i < SLOTS; i++)
			if (peer_valid[i])
				n++;
		r.active = n;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				peer_valid[i] = 1'b0;
				peer_addr[i] = '0;
				peer_stamp[i] = '0;
				burst_count[i] = '0;
			end
			table_touched = 1'b0;
			stale_limit = STALE_TIMEOUT_RESET;
			range_limit = MAX_RANGE_RESET;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STALE_TIMEOUT: stale_limit = cfg_data;
					CFG_MAX_RANGE:     range_limit = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_result(op_t'(operation), peer_address,
					distance_mm, now_ms));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transaction with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("slot_index", 8'(want.slot), 8'(slot_index));
					check_field("status", 8'(want.st), 8'(status));
					check_field("sample_count", 8'(want.samples), 8'(sample_count));
					check_field("active_count", 8'(want.active), 8'(active_count));
					check_field("burst_done", 8'(want.done), 8'(burst_done));
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

### sim/tb_ranging_peer_table.sv
// Testbench top of the ranging peer table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_ranging_peer_table;
	import rpt_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int POOL_SIZE = 10;
	localparam int ITEMS_PER_PHASE = 66;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          operation = '0;
	logic [ADDR_W-1:0]        peer_address = '0;
	logic signed [DIST_W-1:0] distance_mm = '0;
	logic [TIME_W-1:0]        now_ms = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SLOT_W-1:0]        slot_index;
	logic [STATUS_W-1:0]      status;
	logic [SCNT_W-1:0]        sample_count;
	logic [ACNT_W-1:0]        active_count;
	logic                     burst_done;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	int fail_count;
	int pending;
	int in_idle_pct = 31;
	int out_idle_pct = 57;
	int stuck_cycles = 0;
	logic [TIME_W-1:0]  clock_ms = '0;
	logic [RANGE_W-1:0] range_setting = MAX_RANGE_RESET;
	logic [ADDR_W-1:0]  peer_pool [POOL_SIZE];

	ranging_peer_table dut (.*);

	rpt_checker chk (.*, .mismatches(fail_count), .outstanding(pending));

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

	// Counts cycles without any accepted transaction on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("tb_ranging_peer_table NOT OK");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_item(op_t op, logic [ADDR_W-1:0] a, logic [DIST_W-1:0] d,
			logic [TIME_W-1:0] t);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		peer_address <= a;
		distance_mm <= d;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds the sender back until every expected result has been taken.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAX_RANGE)
			range_setting = val[RANGE_W-1:0];
		@(posedge clk);
	endtask

	// Mostly traffic on a small set of peers so that hits, evictions and bursts occur.
	task automatic random_item();
		int pick;
		op_t op;
		logic [ADDR_W-1:0] a;
		logic [DIST_W-1:0] d;
		logic [TIME_W-1:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			op = OP_RANGE;
		else if (pick < 65)
			op = OP_TOUCH;
		else if (pick < 75)
			op = OP_INACTIVE;
		else
			op = OP_TICK;
		if ($urandom_range(0, 9) == 0)
			a = ADDR_W'($urandom);
		else
			a = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
		pick = $urandom_range(0, 99);
		if (pick < 80)
			d = DIST_W'($urandom_range(0, range_setting));
		else if (pick < 90 || range_setting == '1)
			d = {1'b1, 20'($urandom)};
		else
			d = DIST_W'($urandom_range(range_setting + 1, 20'hFFFFF));
		clock_ms += $urandom_range(0, 400);
		t = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
		send_item(op, a, d, t);
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			peer_pool[i] = ADDR_W'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		send_item(OP_TICK, 16'h0000, 21'd0, 32'd0);
		send_item(OP_INACTIVE, 16'h1234, 21'd0, 32'd0);
		send_item(OP_RANGE, 16'h0000, 21'd0, 32'd0);
		send_item(OP_RANGE, 16'hFFFF, 21'd100000, 32'd10);
		send_item(OP_RANGE, 16'hFFFF, 21'd100001, 32'd11);
		send_item(OP_RANGE, 16'hFFFF, 21'h1FFFFF, 32'd12);
		send_item(OP_RANGE, 16'hFFFF, 21'h100000, 32'd13);
		send_item(OP_RANGE, 16'hFFFF, 21'h0FFFFF, 32'd14);
		send_item(OP_RANGE, 16'h0000, 21'd5, 32'd20);
		send_item(OP_TOUCH, 16'h5555, 21'd0, 32'd30);
		send_item(OP_TOUCH, 16'h5555, 21'd0, 32'd31);
		send_item(OP_INACTIVE, 16'hFFFF, 21'd0, 32'd32);
		send_item(OP_TOUCH, 16'hFFFF, 21'd0, 32'd33);
		// Equal stamps on the filled slots exercise the eviction tie.
		for (int i = 0; i < 6; i++)
			send_item(OP_TOUCH, 16'hA000 + 16'(i), 21'd0, 32'd5);
		send_item(OP_RANGE, 16'hBEEF, 21'd77, 32'd40);
		send_item(OP_TICK, 16'h0000, 21'd0, 32'hFFFFFFFF);
		send_item(OP_RANGE, 16'h1111, 21'd7, 32'hFFFFFFF0);
		send_item(OP_TICK, 16'h0000, 21'd0, 32'h00000100);
		send_item(OP_TICK, 16'h0000, 21'd0, 32'h00000300);
		wait_results();
		clock_ms = 32'h00000400;

		for (int phase = 0; phase < 6; phase++) begin
			in_idle_pct = (phase < 2) ? 31 : (phase < 4) ? 57 : 0;
			out_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 31 : 0;
			case (phase)
				0: begin
					write_reg(CFG_STALE_TIMEOUT, 32'd0);
					write_reg(CFG_MAX_RANGE, 32'd0);
				end
				1: begin
					write_reg(CFG_STALE_TIMEOUT, 32'hFFFFFFFF);
					write_reg(CFG_MAX_RANGE, 32'hFFFFFFFF);
				end
				2: begin
					write_reg(CFG_STALE_TIMEOUT, $urandom_range(300, 3000));
					write_reg(CFG_MAX_RANGE, $urandom_range(1000, 20'hFFFFF));
				end
				3: begin
					write_reg(CFG_STALE_TIMEOUT, 32'(STALE_TIMEOUT_RESET));
					write_reg(CFG_MAX_RANGE, 32'(MAX_RANGE_RESET));
					// Run the clock across the 32-bit wrap.
					clock_ms = 32'hFFFFF000;
				end
				4: begin
					write_reg(CFG_STALE_TIMEOUT, $urandom_range(500, 8000));
					write_reg(CFG_MAX_RANGE, $urandom);
				end
				default: begin
					write_reg(CFG_STALE_TIMEOUT, 32'd1000);
					write_reg(CFG_MAX_RANGE, 32'h000FFFFF);
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 1 && n == 33)
					wait_results();
				random_item();
			end
			wait_results();
		end

		if (fail_count == 0)
			$display("tb_ranging_peer_table OK");
		else
			$display("tb_ranging_peer_table NOT OK");
		$finish;
	end

endmodule
